// ===== hdl/ffpa_pkg.sv =====
// Shared types, codes and defaults for the first-fit page allocator.
// Used by the page cell, the top level and the testbench.
`default_nettype none
package ffpa_pkg;

   localparam int unsigned FUNC_W    = 1;
   localparam int unsigned PID_W     = 4;
   localparam int unsigned COUNT_W   = 5;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned START_W   = 4;

   localparam int unsigned PAGE_TOTAL_DEF    = 16;
   localparam int unsigned PROCESS_SLOTS_DEF = 16;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_RUN    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [PID_W-1:0]   process_id;
      logic [COUNT_W-1:0] num_pages;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [START_W-1:0]  start_page;
      logic [COUNT_W-1:0]  page_count;
   } rsp_type;

   // Control flags of the search wave as it moves from cell to cell.
   typedef struct packed {
      logic active;
      logic found;
   } wave_flags_type;

   // Broadcast command that sets or clears the used bits of a page range.
   typedef struct packed {
      logic set;
      logic clear;
   } mark_type;

endpackage
`default_nettype wire

// ===== hdl/ffpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Holds the start page and page count of each allocation record; no package use.
`default_nettype none
module ffpa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/ffpa_cell.sv =====
// One page of the allocator: its used bit and one stage of the search wave.
// Depends on ffpa_pkg for the wave flag and range command types.
`default_nettype none
module ffpa_cell #(
   parameter int unsigned IDX = 0,
   parameter int unsigned PW  = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ffpa_pkg::wave_flags_type         src_flags,
   input  wire logic [ffpa_pkg::COUNT_W-1:0]     src_run,
   input  wire logic [PW-1:0]                    src_first,
   input  wire logic [ffpa_pkg::COUNT_W-1:0]     want,
   input  wire ffpa_pkg::mark_type               mark,
   input  wire logic [PW-1:0]                    mark_lo,
   input  wire logic [ffpa_pkg::COUNT_W-1:0]     mark_count,
   output ffpa_pkg::wave_flags_type              dst_flags,
   output logic      [ffpa_pkg::COUNT_W-1:0]     dst_run,
   output logic      [PW-1:0]                    dst_first
);
   import ffpa_pkg::*;

   localparam int unsigned SW = ((PW > COUNT_W) ? PW : COUNT_W) + 1;

   logic                 used_ff, used_in;
   wave_flags_type       flags_ff, flags_in;
   logic [COUNT_W-1:0]   run_ff, run_in;
   logic [PW-1:0]        first_ff, first_in;
   logic                 in_range;

   always_comb begin
      in_range = (SW'(IDX) >= SW'(mark_lo)) &&
                 (SW'(IDX) < (SW'(mark_lo) + SW'(mark_count)));
      used_in = used_ff;
      if (mark.set && in_range) begin
         used_in = 1'b1;
      end else if (mark.clear && in_range) begin
         used_in = 1'b0;
      end
   end

   // A used page breaks the run; a free page extends it and opens it if it was empty.
   always_comb begin
      flags_in = src_flags;
      run_in   = src_run;
      first_in = src_first;
      if (src_flags.active && !src_flags.found) begin
         if (used_ff) begin
            run_in = '0;
         end else begin
            run_in = src_run + COUNT_W'(1);
            if (src_run == '0) begin
               first_in = PW'(IDX);
            end
            if (run_in == want) begin
               flags_in.found = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         flags_ff <= '0;
      end else begin
         used_ff  <= used_in;
         flags_ff <= flags_in;
      end
      run_ff   <= run_in;
      first_ff <= first_in;
   end

   assign dst_flags = flags_ff;
   assign dst_run   = run_ff;
   assign dst_first = first_ff;

endmodule
`default_nettype wire

// ===== hdl/first_fit_page_allocator.sv =====
// First-fit contiguous page allocator: top level with sequencer and record table.
// Depends on ffpa_pkg, ffpa_cell and ffpa_ram.
//
// The block takes one transaction at a time. An allocation sends a search wave
// down a row of PAGE_TOTAL page cells, one cell per cycle, and completes once the
// wave has left the last cell. A free reads the record RAM (registered read) and
// then completes; an allocation refused for its size goes straight to completion.
// A result waits in the output register while the block already accepts the next
// request, and work only stalls at completion if that register is still full.
// All page bits and record valid bits clear together at reset; there is no
// clearing pass.
`default_nettype none
module first_fit_page_allocator #(
   parameter int unsigned PAGE_TOTAL    = ffpa_pkg::PAGE_TOTAL_DEF,
   parameter int unsigned PROCESS_SLOTS = ffpa_pkg::PROCESS_SLOTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ffpa_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ffpa_pkg::rsp_type      rsp_payload
);
   import ffpa_pkg::*;

   localparam int unsigned PW          = $clog2(PAGE_TOTAL);
   localparam int unsigned PID_SPAN    = 1 << PID_W;
   localparam int unsigned SLOT_DEPTH  = (PROCESS_SLOTS < PID_SPAN) ? PROCESS_SLOTS : PID_SPAN;
   localparam int unsigned AW          = $clog2(SLOT_DEPTH);
   localparam int unsigned CW          = 9;
   localparam int unsigned RAM_W       = PW + COUNT_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic                  start_ff, start_in;
   logic [FUNC_W-1:0]     func_ff, func_in;
   logic [PID_W-1:0]      pid_ff, pid_in;
   logic                  pid_ok_ff, pid_ok_in;
   logic [COUNT_W-1:0]    want_ff, want_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [PW-1:0]         res_start_ff, res_start_in;
   logic [COUNT_W-1:0]    res_count_ff, res_count_in;
   logic                  do_alloc_ff, do_alloc_in;
   logic                  do_free_ff, do_free_in;
   logic [SLOT_DEPTH-1:0] entry_valid_ff, entry_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_payload_ff, rsp_payload_in;

   logic                  req_accept;
   logic                  out_free;
   logic                  commit;
   logic                  req_pid_ok;
   logic                  too_large;
   mark_type              mark;
   logic [RAM_W-1:0]      ram_rd_data;
   logic [PW-1:0]         ram_start;
   logic [COUNT_W-1:0]    ram_count;
   logic [PW+START_W-1:0] start_wide;

   wave_flags_type        wave_flags [PAGE_TOTAL+1];
   logic [COUNT_W-1:0]    wave_run   [PAGE_TOTAL+1];
   logic [PW-1:0]         wave_first [PAGE_TOTAL+1];

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign commit     = (state_ff == ST_FINISH) && out_free;
   assign req_pid_ok = (CW'(req_payload.process_id) < CW'(PROCESS_SLOTS));
   assign too_large  = (CW'(req_payload.num_pages) > CW'(PAGE_TOTAL));
   assign ram_start  = ram_rd_data[RAM_W-1:COUNT_W];
   assign ram_count  = ram_rd_data[COUNT_W-1:0];
   assign mark.set   = commit && do_alloc_ff;
   assign mark.clear = commit && do_free_ff;
   assign start_wide = (PW+START_W)'(res_start_ff);

   // The search wave enters the first cell the cycle after acceptance.
   assign wave_flags[0] = '{active: start_ff, found: 1'b0};
   assign wave_run[0]   = '0;
   assign wave_first[0] = '0;

   for (genvar g = 0; g < PAGE_TOTAL; g++) begin : g_cell
      ffpa_cell #(
         .IDX (g),
         .PW  (PW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .src_flags  (wave_flags[g]),
         .src_run    (wave_run[g]),
         .src_first  (wave_first[g]),
         .want       (want_ff),
         .mark       (mark),
         .mark_lo    (res_start_ff),
         .mark_count (res_count_ff),
         .dst_flags  (wave_flags[g+1]),
         .dst_run    (wave_run[g+1]),
         .dst_first  (wave_first[g+1])
      );
   end

   ffpa_ram #(
      .WIDTH (RAM_W),
      .DEPTH (SLOT_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mark.set),
      .wr_addr (pid_ff[AW-1:0]),
      .wr_data ({res_start_ff, res_count_ff}),
      .rd_en   (req_accept),
      .rd_addr (req_payload.process_id[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      start_in       = 1'b0;
      func_in        = func_ff;
      pid_in         = pid_ff;
      pid_ok_in      = pid_ok_ff;
      want_in        = want_ff;
      res_status_in  = res_status_ff;
      res_start_in   = res_start_ff;
      res_count_in   = res_count_ff;
      do_alloc_in    = do_alloc_ff;
      do_free_in     = do_free_ff;
      entry_valid_in = entry_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               func_in      = req_payload.func;
               pid_in       = req_payload.process_id;
               pid_ok_in    = req_pid_ok;
               want_in      = req_payload.num_pages;
               res_start_in = '0;
               res_count_in = '0;
               do_alloc_in  = 1'b0;
               do_free_in   = 1'b0;
               if (req_payload.func == FUNC_FREE) begin
                  state_in = ST_READ;
               end else if (too_large) begin
                  res_status_in = STATUS_TOO_LARGE;
                  state_in      = ST_FINISH;
               end else if (req_payload.num_pages == '0 || !req_pid_ok) begin
                  res_status_in = STATUS_NO_RUN;
                  state_in      = ST_FINISH;
               end else begin
                  start_in = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (wave_flags[PAGE_TOTAL].active) begin
               state_in = ST_FINISH;
               if (wave_flags[PAGE_TOTAL].found) begin
                  res_status_in = STATUS_OK;
                  res_start_in  = wave_first[PAGE_TOTAL];
                  res_count_in  = want_ff;
                  do_alloc_in   = 1'b1;
               end else begin
                  res_status_in = STATUS_NO_RUN;
               end
            end
         end
         ST_READ: begin
            state_in = ST_FINISH;
            if (pid_ok_ff && entry_valid_ff[pid_ff[AW-1:0]]) begin
               res_status_in = STATUS_OK;
               res_start_in  = ram_start;
               res_count_in  = ram_count;
               do_free_in    = 1'b1;
            end else begin
               res_status_in = STATUS_NOT_FOUND;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
               if (do_alloc_ff) begin
                  entry_valid_in[pid_ff[AW-1:0]] = 1'b1;
               end else if (do_free_ff) begin
                  entry_valid_in[pid_ff[AW-1:0]] = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (commit) begin
         rsp_valid_in              = 1'b1;
         rsp_payload_in.status     = res_status_ff;
         rsp_payload_in.start_page = start_wide[START_W-1:0];
         rsp_payload_in.page_count = res_count_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         start_ff       <= 1'b0;
         do_alloc_ff    <= 1'b0;
         do_free_ff     <= 1'b0;
         entry_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         start_ff       <= start_in;
         do_alloc_ff    <= do_alloc_in;
         do_free_ff     <= do_free_in;
         entry_valid_ff <= entry_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      func_ff        <= func_in;
      pid_ff         <= pid_in;
      pid_ok_ff      <= pid_ok_in;
      want_ff        <= want_in;
      res_status_ff  <= res_status_in;
      res_start_ff   <= res_start_in;
      res_count_ff   <= res_count_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A failed transaction reports no pages, a successful one at least one.
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.status == STATUS_OK) ?
                     (rsp_payload.page_count != '0) :
                     (rsp_payload.page_count == '0 && rsp_payload.start_page == '0)))
      else $error("response count does not match its status");

   // Once a request is taken, no further request is taken in the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("request accepted while the previous one is in progress");

   // The search wave leaves the row of cells only while a scan is in progress.
   a_wave_in_scan: assert property (@(posedge clock) disable iff (reset)
      wave_flags[PAGE_TOTAL].active |-> (state_ff == ST_SCAN))
      else $error("search wave completed outside a scan");

   // Only an allocation can mark pages used, only a free can release them.
   a_mark_kind: assert property (@(posedge clock) disable iff (reset)
      (mark.set |-> func_ff == FUNC_ALLOC) and (mark.clear |-> func_ff == FUNC_FREE))
      else $error("page range updated by the wrong kind of transaction");

endmodule
`default_nettype wire

// ===== tb/tb_first_fit_page_allocator.sv =====
// Self-checking testbench for first_fit_page_allocator: directed, random and back-pressure tests.
// An in-bench page map and record table predict each result. Depends on ffpa_pkg and the RTL.
`timescale 1ns / 100ps
module tb_first_fit_page_allocator;
   import ffpa_pkg::*;

   localparam int unsigned PAGES       = PAGE_TOTAL_DEF;
   localparam int unsigned SLOTS       = PROCESS_SLOTS_DEF;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned CYCLE_LIMIT = 200000;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   // Predicted allocator state.
   logic [PAGES-1:0]   page_busy = '0;
   logic [SLOTS-1:0]   rec_valid = '0;
   logic [START_W-1:0] rec_start [SLOTS];
   logic [COUNT_W-1:0] rec_count [SLOTS];

   rsp_type     outcomes_due[$];
   int unsigned errors           = 0;
   int unsigned cycle_count      = 0;
   bit          req_held         = 1'b0;
   bit          quiet_sender     = 1'b0;
   bit          quiet_receiver   = 1'b0;
   int unsigned overwrite_budget = 3;
   int unsigned hold_orders      = 0;
   int unsigned hold_seen        = 0;
   int unsigned stall_left       = 0;

   first_fit_page_allocator #(
      .PAGE_TOTAL    (PAGES),
      .PROCESS_SLOTS (SLOTS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Applies one transaction to the predicted state and returns the result it must give.
   function automatic rsp_type predict_page_outcome(input req_type item);
      rsp_type     outcome;
      int unsigned pid;
      int unsigned want;
      int unsigned run;
      int unsigned first;
      int unsigned count;
      bit          found;
      outcome = '0;
      pid     = 32'(item.process_id);
      want    = 32'(item.num_pages);
      run     = 0;
      first   = 0;
      found   = 1'b0;
      if (item.func == FUNC_ALLOC) begin
         if (want > PAGES) begin
            outcome.status = STATUS_TOO_LARGE;
         end else if (want == 0 || pid >= SLOTS) begin
            outcome.status = STATUS_NO_RUN;
         end else begin
            outcome.status = STATUS_NO_RUN;
            for (int i = 0; i < PAGES; i++) begin
               if (!found) begin
                  if (page_busy[i]) begin
                     run = 0;
                  end else begin
                     if (run == 0) first = i;
                     run++;
                     if (run == want) found = 1'b1;
                  end
               end
            end
            if (found) begin
               for (int j = first; j < first + want; j++) page_busy[j] = 1'b1;
               rec_valid[pid]     = 1'b1;
               rec_start[pid]     = START_W'(first);
               rec_count[pid]     = COUNT_W'(want);
               outcome.status     = STATUS_OK;
               outcome.start_page = START_W'(first);
               outcome.page_count = COUNT_W'(want);
            end
         end
      end else if (pid >= SLOTS || !rec_valid[pid]) begin
         outcome.status = STATUS_NOT_FOUND;
      end else begin
         first = 32'(rec_start[pid]);
         count = 32'(rec_count[pid]);
         // Pages are cleared whoever holds them now; anything past the end is skipped.
         for (int j = first; j < first + count; j++) begin
            if (j < PAGES) page_busy[j] = 1'b0;
         end
         rec_valid[pid]     = 1'b0;
         outcome.status     = STATUS_OK;
         outcome.start_page = rec_start[pid];
         outcome.page_count = rec_count[pid];
      end
      return outcome;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet_sender) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // Offers one transaction and records its expected result once it is accepted.
   // Valid stays high after acceptance so that a following item can go out at once.
   task automatic send_request(input logic [FUNC_W-1:0] func, input int unsigned pid,
                               input int unsigned pages);
      req_type     item;
      int unsigned gap;
      item.func       = func;
      item.process_id = PID_W'(pid);
      item.num_pages  = COUNT_W'(pages);
      gap             = pick_gap();
      if (gap != 0 && req_held) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
      repeat (gap) @(posedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      outcomes_due.push_back(predict_page_outcome(item));
      req_held = 1'b1;
   endtask

   task automatic wait_idle();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
      do @(posedge clock); while (outcomes_due.size() != 0);
   endtask

   // Mostly well-formed allocate/free traffic on real process records, with some noise.
   task automatic send_random_request();
      int unsigned absent[$];
      int unsigned present[$];
      int unsigned roll;
      int unsigned pages;
      for (int p = 0; p < SLOTS; p++) begin
         if (rec_valid[p]) present.push_back(p);
         else absent.push_back(p);
      end
      roll  = $urandom_range(0, 99);
      pages = $urandom_range(0, 99);
      if (pages < 80) pages = $urandom_range(1, 4);
      else if (pages < 95) pages = $urandom_range(5, 8);
      else pages = $urandom_range(9, PAGES);
      if (roll >= 96 && overwrite_budget != 0 && present.size() != 0) begin
         // Re-allocating a live process leaks its old pages, so keep these few and small.
         overwrite_budget--;
         send_request(FUNC_ALLOC, present[$urandom_range(0, present.size() - 1)], 1);
      end else if (roll < 45 && absent.size() != 0 || present.size() == 0 && roll < 85) begin
         send_request(FUNC_ALLOC, absent[$urandom_range(0, absent.size() - 1)], pages);
      end else if (roll < 85) begin
         send_request(FUNC_FREE, present[$urandom_range(0, present.size() - 1)],
                      $urandom_range(0, 31));
      end else if (roll < 89) begin
         send_request(FUNC_ALLOC, $urandom_range(0, SLOTS - 1), $urandom_range(PAGES + 1, 31));
      end else if (roll < 92) begin
         send_request(FUNC_ALLOC, $urandom_range(0, SLOTS - 1), 0);
      end else if (absent.size() != 0) begin
         send_request(FUNC_FREE, absent[$urandom_range(0, absent.size() - 1)],
                      $urandom_range(0, 31));
      end else begin
         send_request(FUNC_FREE, present[$urandom_range(0, present.size() - 1)], 0);
      end
   endtask

   task automatic test_directed_cases();
      send_request(FUNC_ALLOC, 0, PAGES);      // whole memory
      send_request(FUNC_ALLOC, 1, 1);          // nothing left
      send_request(FUNC_FREE, 0, 31);
      send_request(FUNC_ALLOC, 1, PAGES + 1);  // larger than memory
      send_request(FUNC_ALLOC, 2, 31);
      send_request(FUNC_ALLOC, 3, 0);          // zero pages
      send_request(FUNC_FREE, 15, 0);          // absent process
      send_request(FUNC_ALLOC, 15, 1);
      send_request(FUNC_ALLOC, 14, 3);
      send_request(FUNC_ALLOC, 13, 2);
      send_request(FUNC_FREE, 14, 0);
      send_request(FUNC_ALLOC, 12, 4);         // the hole is too short and is skipped
      send_request(FUNC_ALLOC, 11, 3);         // fills the hole exactly
      send_request(FUNC_ALLOC, 10, 2);
      send_request(FUNC_ALLOC, 15, 1);         // overwrites a live record, page 0 stays used
      send_request(FUNC_FREE, 15, 0);
      send_request(FUNC_FREE, 15, 0);
      send_request(FUNC_FREE, 13, 0);
      send_request(FUNC_FREE, 12, 0);
      send_request(FUNC_FREE, 11, 0);
      send_request(FUNC_FREE, 10, 0);
      send_request(FUNC_ALLOC, 9, PAGES);      // the leaked page blocks a full-size run
      send_request(FUNC_ALLOC, 9, PAGES - 1);
      send_request(FUNC_FREE, 9, 0);
      wait_idle();
   endtask

   task automatic test_random_mix(input int unsigned count);
      quiet_sender   = 1'b0;
      quiet_receiver = 1'b0;
      repeat (count) send_random_request();
      wait_idle();
   endtask

   task automatic test_back_to_back(input int unsigned count);
      quiet_sender   = 1'b1;
      quiet_receiver = 1'b1;
      repeat (count) send_random_request();
      wait_idle();
      quiet_sender   = 1'b0;
      quiet_receiver = 1'b0;
   endtask

   // The receiver holds off for a long stretch while transactions keep coming, so the
   // block fills and stalls its input; the sender then waits for every result.
   task automatic test_output_backpressure(input int unsigned count);
      quiet_sender = 1'b1;
      hold_orders <= hold_orders + 1;
      repeat (count) send_random_request();
      quiet_sender = 1'b0;
      wait_idle();
   endtask

   always @(posedge clock) begin : receiver_stall
      int unsigned roll;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (hold_seen != hold_orders) begin
         hold_seen  <= hold_orders;
         stall_left <= HOLD_CYCLES - 1;
         rsp_stall  <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (quiet_receiver) begin
         rsp_stall <= 1'b0;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 20) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else if (roll < 23) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(8, 40);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void compare_field(input string field, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : outcome_check
      rsp_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcomes_due.size() == 0) begin
            $display("%0t: unexpected transaction: status %0d, start %0d, count %0d",
                     $time, rsp_payload.status, rsp_payload.start_page, rsp_payload.page_count);
            errors++;
         end else begin
            due = outcomes_due.pop_front();
            compare_field("status", 8'(due.status), 8'(rsp_payload.status));
            compare_field("start_page", 8'(due.start_page), 8'(rsp_payload.start_page));
            compare_field("page_count", 8'(due.page_count), 8'(rsp_payload.page_count));
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_mix(330);
      test_back_to_back(60);
      test_output_backpressure(40);
      repeat (PAGES + 5) @(posedge clock);
      if (errors == 0 && outcomes_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
